>>> hw/rtl/bmah_pkg.sv
// bmah_pkg: types and constants shared by the battery monitor modules.
// No dependencies.

package bmah_pkg;

    localparam int MV_W       = 15;
    localparam int TAP_W      = 12;
    localparam int RATIO_W    = 12;
    localparam int PROD_W     = TAP_W + RATIO_W;
    localparam int PCT_W      = 7;
    localparam int DIVIDEND_W = 22;
    localparam int DIVISOR_W  = 15;
    localparam int QUOT_W     = 15;
    localparam int NBITS_W    = 4;
    localparam int DSH_W      = DIVISOR_W + QUOT_W - 1;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [MV_W-1:0]    MV_MAX      = 15'd32767;
    localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
    localparam logic [NBITS_W-1:0] AVG_QBITS   = 4'd15;
    localparam logic [NBITS_W-1:0] PCT_QBITS   = 4'd7;

    localparam logic [RATIO_W-1:0] RATIO_RST      = 12'd1270;
    localparam logic [MV_W-1:0]    FULL_RST       = 15'd12100;
    localparam logic [MV_W-1:0]    EMPTY_RST      = 15'd9600;
    localparam logic [MV_W-1:0]    WARN_RST       = 15'd10800;
    localparam logic [MV_W-1:0]    CRIT_RST       = 15'd10500;
    localparam logic [MV_W-1:0]    LOW_RECOV_RST  = 15'd11000;
    localparam logic [MV_W-1:0]    CRIT_RECOV_RST = 15'd10700;

    typedef enum logic [2:0] {
        REG_RATIO      = 3'd0,
        REG_FULL       = 3'd1,
        REG_EMPTY      = 3'd2,
        REG_WARN       = 3'd3,
        REG_CRIT       = 3'd4,
        REG_LOW_RECOV  = 3'd5,
        REG_CRIT_RECOV = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_UNINIT = 2'd0,
        ST_NORMAL = 2'd1,
        ST_LOW    = 2'd2,
        ST_CRIT   = 2'd3
    } bat_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_RING,
        S_AVG_START,
        S_AVG_WAIT,
        S_STATUS,
        S_PCT_START,
        S_PCT_WAIT,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic [RATIO_W-1:0] divider_ratio_q8;
        logic [MV_W-1:0]    full_mv;
        logic [MV_W-1:0]    empty_mv;
        logic [MV_W-1:0]    warn_mv;
        logic [MV_W-1:0]    crit_mv;
        logic [MV_W-1:0]    low_recover_mv;
        logic [MV_W-1:0]    crit_recover_mv;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [NBITS_W-1:0]    nbits;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hw/rtl/bmah_regs.sv
// bmah_regs: APB-style configuration register file.
// Depends on bmah_pkg.

module bmah_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bmah_pkg::ADDR_W-1:0] paddr,
    input  logic [bmah_pkg::DATA_W-1:0] pwdata,
    output logic [bmah_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output bmah_pkg::cfg_t            cfg
);
    import bmah_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.divider_ratio_q8 <= RATIO_RST;
            cfg_reg.full_mv          <= FULL_RST;
            cfg_reg.empty_mv         <= EMPTY_RST;
            cfg_reg.warn_mv          <= WARN_RST;
            cfg_reg.crit_mv          <= CRIT_RST;
            cfg_reg.low_recover_mv   <= LOW_RECOV_RST;
            cfg_reg.crit_recover_mv  <= CRIT_RECOV_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_RATIO:      cfg_reg.divider_ratio_q8 <= pwdata[RATIO_W-1:0];
                REG_FULL:       cfg_reg.full_mv          <= pwdata[MV_W-1:0];
                REG_EMPTY:      cfg_reg.empty_mv         <= pwdata[MV_W-1:0];
                REG_WARN:       cfg_reg.warn_mv          <= pwdata[MV_W-1:0];
                REG_CRIT:       cfg_reg.crit_mv          <= pwdata[MV_W-1:0];
                REG_LOW_RECOV:  cfg_reg.low_recover_mv   <= pwdata[MV_W-1:0];
                REG_CRIT_RECOV: cfg_reg.crit_recover_mv  <= pwdata[MV_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_RATIO:      prdata = DATA_W'(cfg_reg.divider_ratio_q8);
            REG_FULL:       prdata = DATA_W'(cfg_reg.full_mv);
            REG_EMPTY:      prdata = DATA_W'(cfg_reg.empty_mv);
            REG_WARN:       prdata = DATA_W'(cfg_reg.warn_mv);
            REG_CRIT:       prdata = DATA_W'(cfg_reg.crit_mv);
            REG_LOW_RECOV:  prdata = DATA_W'(cfg_reg.low_recover_mv);
            REG_CRIT_RECOV: prdata = DATA_W'(cfg_reg.crit_recover_mv);
            default:        prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/bmah_div.sv
// bmah_div: shared restoring divider, one quotient bit per cycle.
// Depends on bmah_pkg. Caller guarantees dividend < divisor << nbits.

module bmah_div (
    input  logic               clk,
    input  logic               rst_n,
    input  bmah_pkg::div_req_t req,
    output bmah_pkg::div_rsp_t rsp
);
    import bmah_pkg::*;

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DSH_W-1:0]      dsh_reg;
    logic [QUOT_W-1:0]     q_reg;
    logic [NBITS_W-1:0]    cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  fits;

    assign fits         = {(DSH_W-DIVIDEND_W)'(0), rem_reg} >= dsh_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NBITS_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            dsh_reg <= DSH_W'(req.divisor) << (req.nbits - 1'b1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= rem_reg - dsh_reg[DIVIDEND_W-1:0];
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[QUOT_W-2:0], fits};
        end
    end

endmodule

>>> hw/rtl/battery_monitor_avg_hysteresis.sv
// battery_monitor_avg_hysteresis: top level of the battery monitor.
// Depends on bmah_pkg, bmah_regs, bmah_div.
//
// Usage:
//   s_* channel: one divider-tap sample per transfer, s_tdata[11:0] = tap_mv.
//   m_* channel: one result per sample, 40-bit m_tdata.
//   APB port: seven threshold/ratio registers at byte addresses 0..24.
//   Each sample is scaled by the Q8 ratio, pushed into a WINDOW-deep ring
//   with a running sum, averaged, classified with hysteresis once the ring
//   has filled, and converted to a 0..100 charge percentage.
//   Each sample passes the scale, ring, mean-division and status states,
//   then the percent-division states when the percent needs a division,
//   before the output state; the shared divider serves both divisions.
//   s_tready is high only while the sequencer is idle, so a new sample is
//   taken only after the previous result has been loaded for output.
//   Reset clears the ring, sum, fill count and status; registers return to
//   their defaults. A stalled m_tready holds the result in the output
//   register; the next sample may be taken meanwhile but finishes only
//   after the held result has been transferred.

module battery_monitor_avg_hysteresis #(
    parameter int WINDOW = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmah_pkg::ADDR_W-1:0] paddr,
    input  logic [bmah_pkg::DATA_W-1:0] pwdata,
    output logic [bmah_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,  // [11:0] tap_mv
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [14:0] battery_mv, [29:15] average_mv, [30] window_full,
    // [32:31] status, [39:33] percent
    output logic [39:0]                 m_tdata
);
    import bmah_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = MV_W + $clog2(WINDOW);

    cfg_t       cfg;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    seq_state_t state_reg, state_next;
    bat_state_t bat_reg, bat_next;

    logic [MV_W-1:0]       ring_reg [WINDOW];
    logic [SUM_W-1:0]      sum_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [MV_W-1:0]       mv_reg;
    logic [MV_W-1:0]       old_reg;
    logic [MV_W-1:0]       avg_reg;
    logic [PCT_W-1:0]      pct_reg;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [DIVISOR_W-1:0]  span_reg;

    logic                  m_tvalid_reg;
    logic [39:0]           m_tdata_reg;

    logic                  in_xfer;
    logic                  out_load;
    logic                  win_full;
    logic [MV_W-1:0]       span;

    bmah_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bmah_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_xfer  = s_tvalid && s_tready;
    assign win_full = (fill_reg == FILL_W'(WINDOW));
    assign span     = cfg.full_mv - cfg.empty_mv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIVIDEND_W'(sum_reg);
        div_req.divisor  = DIVISOR_W'(WINDOW);
        div_req.nbits    = AVG_QBITS;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = S_SCALE;
            end
            S_SCALE:     state_next = S_RING;
            S_RING:      state_next = S_AVG_START;
            S_AVG_START:
            begin
                div_req.start = 1'b1;
                state_next    = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_rsp.done)
                    state_next = S_STATUS;
            end
            S_STATUS:
            begin
                if (mv_reg <= cfg.empty_mv || cfg.full_mv <= cfg.empty_mv
                    || mv_reg >= cfg.full_mv)
                    state_next = S_OUT;
                else
                    state_next = S_PCT_START;
            end
            S_PCT_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_reg;
                div_req.divisor  = span_reg;
                div_req.nbits    = PCT_QBITS;
                state_next       = S_PCT_WAIT;
            end
            S_PCT_WAIT:
            begin
                div_req.dividend = num_reg;
                div_req.divisor  = span_reg;
                div_req.nbits    = PCT_QBITS;
                if (div_rsp.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // hysteresis classifier on the mean
    always_comb
    begin
        bat_next = bat_reg;
        case (bat_reg)
            ST_LOW:
            begin
                if (avg_reg <= cfg.crit_mv)
                    bat_next = ST_CRIT;
                else if (avg_reg >= cfg.low_recover_mv)
                    bat_next = ST_NORMAL;
            end
            ST_CRIT:
            begin
                if (avg_reg >= cfg.low_recover_mv)
                    bat_next = ST_NORMAL;
                else if (avg_reg >= cfg.crit_recover_mv)
                    bat_next = ST_LOW;
            end
            default:
            begin
                if (avg_reg <= cfg.crit_mv)
                    bat_next = ST_CRIT;
                else if (avg_reg <= cfg.warn_mv)
                    bat_next = ST_LOW;
                else
                    bat_next = ST_NORMAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
                ring_reg[i] <= '0;
            sum_reg      <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            bat_reg      <= ST_UNINIT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_RING)
            begin
                ring_reg[slot_reg] <= mv_reg;
                sum_reg <= sum_reg - SUM_W'(old_reg) + SUM_W'(mv_reg);
                if (slot_reg == SLOT_W'(WINDOW - 1))
                    slot_reg <= '0;
                else
                    slot_reg <= slot_reg + SLOT_W'(1);
                if (!win_full)
                    fill_reg <= fill_reg + FILL_W'(1);
            end
            if (state_reg == S_STATUS && win_full)
                bat_reg <= bat_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            prod_reg <= PROD_W'(s_tdata[TAP_W-1:0]) * PROD_W'(cfg.divider_ratio_q8);
        if (state_reg == S_SCALE)
        begin
            mv_reg  <= prod_reg[PROD_W-1] ? MV_MAX : prod_reg[PROD_W-2:8];
            old_reg <= ring_reg[slot_reg];
        end
        if (state_reg == S_AVG_WAIT && div_rsp.done)
            avg_reg <= div_rsp.quotient;
        if (state_reg == S_STATUS)
        begin
            num_reg  <= DIVIDEND_W'(mv_reg - cfg.empty_mv) * DIVIDEND_W'(PCT_FULL);
            span_reg <= span;
            if (mv_reg <= cfg.empty_mv)
                pct_reg <= '0;
            else
                pct_reg <= PCT_FULL;
        end
        if (state_reg == S_PCT_WAIT && div_rsp.done)
            pct_reg <= div_rsp.quotient[PCT_W-1:0];
        if (out_load)
            m_tdata_reg <= {pct_reg, bat_reg, win_full, avg_reg, mv_reg};
    end

endmodule

>>> dv/bmah_checker.sv
// bmah_checker: tracks register writes and accepted samples on the battery monitor ports,
// predicts each reading and compares it with the result stream.
// Depends on bmah_pkg.

module bmah_checker
    import bmah_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    output int                outstanding,
    output int                mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [MV_W-1:0]  battery_mv;
        logic [MV_W-1:0]  average_mv;
        logic             window_full;
        bat_state_t       status;
        logic [PCT_W-1:0] percent;
    } reading_t;

    logic [RATIO_W-1:0] ratio_q8;
    logic [MV_W-1:0]    full_lvl;
    logic [MV_W-1:0]    empty_lvl;
    logic [MV_W-1:0]    warn_lvl;
    logic [MV_W-1:0]    crit_lvl;
    logic [MV_W-1:0]    recover_lvl;
    logic [MV_W-1:0]    crit_up_lvl;

    logic [MV_W-1:0]    ring_mv [WINDOW];
    logic [18:0]        sum_mv;
    int unsigned        next_slot;
    int unsigned        taps_seen;
    bat_state_t         charge_state;

    reading_t           readings_due [$];

    function automatic reading_t expected_reading(logic [TAP_W-1:0] tap);
        logic [PROD_W-1:0] product;
        logic [MV_W-1:0]   mv;
        logic [18:0]       avg;
        logic [21:0]       span_pct;
        logic [21:0]       pct;
        reading_t          r;
        product = PROD_W'(tap) * PROD_W'(ratio_q8);
        mv = product[PROD_W-1] ? MV_MAX : product[PROD_W-2:8];

        sum_mv = sum_mv - 19'(ring_mv[next_slot]) + 19'(mv);
        ring_mv[next_slot] = mv;
        next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
        if (taps_seen < WINDOW)
            taps_seen++;
        avg = sum_mv / 19'(WINDOW);

        // hysteresis only once the window holds real samples
        if (taps_seen == WINDOW)
        begin
            case (charge_state)
                ST_LOW:
                begin
                    if (avg <= crit_lvl)
                        charge_state = ST_CRIT;
                    else if (avg >= recover_lvl)
                        charge_state = ST_NORMAL;
                end
                ST_CRIT:
                begin
                    if (avg >= recover_lvl)
                        charge_state = ST_NORMAL;
                    else if (avg >= crit_up_lvl)
                        charge_state = ST_LOW;
                end
                default:
                begin
                    if (avg <= crit_lvl)
                        charge_state = ST_CRIT;
                    else if (avg <= warn_lvl)
                        charge_state = ST_LOW;
                    else
                        charge_state = ST_NORMAL;
                end
            endcase
        end

        if (mv <= empty_lvl)
            pct = '0;
        else if (full_lvl <= empty_lvl)
            pct = 22'(PCT_FULL);
        else
        begin
            span_pct = 22'(mv - empty_lvl) * 22'd100;
            pct = span_pct / 22'(full_lvl - empty_lvl);
            if (pct > 22'(PCT_FULL))
                pct = 22'(PCT_FULL);
        end

        r.battery_mv  = mv;
        r.average_mv  = avg[MV_W-1:0];
        r.window_full = (taps_seen == WINDOW);
        r.status      = charge_state;
        r.percent     = pct[PCT_W-1:0];
        return r;
    endfunction

    function automatic int field_mismatch(string field, int want, int got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        reading_t want;
        if (!rst_n)
        begin
            ratio_q8     <= RATIO_RST;
            full_lvl     <= FULL_RST;
            empty_lvl    <= EMPTY_RST;
            warn_lvl     <= WARN_RST;
            crit_lvl     <= CRIT_RST;
            recover_lvl  <= LOW_RECOV_RST;
            crit_up_lvl  <= CRIT_RECOV_RST;
            for (int i = 0; i < WINDOW; i++)
                ring_mv[i] = '0;
            sum_mv       = '0;
            next_slot    = 0;
            taps_seen    = 0;
            charge_state = ST_UNINIT;
            outstanding  <= 0;
            mismatches   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_RATIO:      ratio_q8    <= pwdata[RATIO_W-1:0];
                    REG_FULL:       full_lvl    <= pwdata[MV_W-1:0];
                    REG_EMPTY:      empty_lvl   <= pwdata[MV_W-1:0];
                    REG_WARN:       warn_lvl    <= pwdata[MV_W-1:0];
                    REG_CRIT:       crit_lvl    <= pwdata[MV_W-1:0];
                    REG_LOW_RECOV:  recover_lvl <= pwdata[MV_W-1:0];
                    REG_CRIT_RECOV: crit_up_lvl <= pwdata[MV_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                readings_due.push_back(expected_reading(s_tdata[TAP_W-1:0]));

            if (m_tvalid && m_tready)
            begin
                if (readings_due.size() == 0)
                begin
                    $display("%0t: unexpected reading, expected none, actual 0x%010h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    mismatches += field_mismatch("battery_mv", want.battery_mv, m_tdata[14:0]);
                    mismatches += field_mismatch("average_mv", want.average_mv, m_tdata[29:15]);
                    mismatches += field_mismatch("window_full", want.window_full, m_tdata[30]);
                    mismatches += field_mismatch("status", int'(want.status), m_tdata[32:31]);
                    mismatches += field_mismatch("percent", want.percent, m_tdata[39:33]);
                end
            end

            outstanding <= readings_due.size();
        end
    end

endmodule

>>> dv/battery_monitor_avg_hysteresis_test.sv
// battery_monitor_avg_hysteresis_test: drives samples, register writes and result backpressure
// into the battery monitor and reports the verdict from the checker's mismatch and outstanding counts.
// Depends on bmah_pkg, battery_monitor_avg_hysteresis and bmah_checker.

module battery_monitor_avg_hysteresis_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bmah_pkg::*;

    localparam int         WINDOW      = 5;
    localparam int         HOLD_CYCLES = 400;
    localparam int         QUIET_LIMIT = 3000;
    localparam int         TAIL_CYCLES = 60;
    localparam logic [2:0] UNUSED_IDX  = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // [11:0] tap_mv
    logic              m_tvalid;
    logic              m_tready;
    // [14:0] battery_mv, [29:15] average_mv, [30] window_full,
    // [32:31] status, [39:33] percent
    logic [39:0]       m_tdata;

    int                outstanding;
    int                mismatches;
    int                quiet_cycles;
    int                hold_reqs;
    int                burst_left;

    logic [RATIO_W-1:0] cur_ratio;
    int                 band_lo;
    int                 band_hi;
    int                 level_mv;

    battery_monitor_avg_hysteresis #(.WINDOW(WINDOW)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bmah_checker #(.WINDOW(WINDOW)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [DATA_W-1:0] ratio, full, empty, warn, crit,
                             lrec, crec);
        int lo;
        int hi;
        apb_write(REG_RATIO, ratio);
        apb_write(REG_FULL, full);
        apb_write(REG_EMPTY, empty);
        apb_write(REG_WARN, warn);
        apb_write(REG_CRIT, crit);
        apb_write(REG_LOW_RECOV, lrec);
        apb_write(REG_CRIT_RECOV, crec);
        cur_ratio = ratio[RATIO_W-1:0];
        lo = (crit[14:0] < warn[14:0]) ? crit[14:0] : warn[14:0];
        hi = (lrec[14:0] > crec[14:0]) ? lrec[14:0] : crec[14:0];
        if (hi < lo)
        begin
            band_lo = hi;
            band_hi = lo;
        end
        else
        begin
            band_lo = lo;
            band_hi = hi;
        end
        band_lo  = (band_lo > 800) ? band_lo - 800 : 0;
        band_hi  = (band_hi < 32767 - 800) ? band_hi + 800 : 32767;
        level_mv = (band_lo + band_hi) / 2;
    endtask

    // battery level drifts slowly through the threshold band; some samples are noise
    function automatic logic [TAP_W-1:0] drift_tap();
        int pick;
        int t;
        pick = $urandom_range(0, 99);
        if (pick < 15 || cur_ratio == 0)
            return TAP_W'($urandom_range(0, 4095));
        if (pick < 18)
            return pick[0] ? 12'hFFF : 12'h000;
        if (pick < 22)
            level_mv = $urandom_range(band_lo, band_hi);
        else
            level_mv = level_mv + $urandom_range(0, 600) - 300;
        if (level_mv < band_lo)
            level_mv = band_lo;
        if (level_mv > band_hi)
            level_mv = band_hi;
        t = (level_mv * 256) / cur_ratio + $urandom_range(0, 6) - 3;
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        return t[TAP_W-1:0];
    endfunction

    task automatic send_tap(input logic [TAP_W-1:0] tap);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, tap};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_tap(drift_tap());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : receiver
        int mode;
        int span;
        int holds_done;
        m_tready = 1'b0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_reqs != holds_done)
            begin
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                holds_done = hold_reqs;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(1, 40);
                for (int n = 0; n < span; n++)
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= $urandom_range(0, 1);
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        hold_reqs  = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes, then walk normal -> low -> critical -> low -> normal
        send_tap(12'h000);
        send_tap(12'hFFF);
        repeat (4) send_tap(12'd2500);
        repeat (4) send_tap(12'd2180);
        repeat (4) send_tap(12'd2150);
        repeat (4) send_tap(12'd2000);
        repeat (4) send_tap(12'd2200);
        repeat (3) send_tap(12'd2300);
        drain();

        configure(1270, 12100, 9600, 10800, 10500, 11000, 10700);
        send_random(100);
        hold_reqs++;
        send_random(200);
        drain();

        // saturating ratio; a write past the register list must change nothing
        configure(4095, 12100, 9600, 10800, 10500, 11000, 10700);
        apb_write(UNUSED_IDX, $urandom());
        send_random(100);
        drain();

        configure(0, 0, 0, 0, 0, 0, 0);
        send_random(40);
        drain();

        configure(4095, 32767, 32767, 32767, 32767, 32767, 32767);
        send_random(60);
        drain();

        // full below empty, crossed thresholds
        configure(1000, 9000, 11000, 10000, 10400, 9800, 10600);
        send_random(150);
        drain();

        repeat (3)
        begin
            configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom());
            send_random(60);
            drain();
        end

        configure(1270, 12600, 8800, 11200, 10300, 11500, 10900);
        send_random(350);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bmah_pkg.sv
hw/rtl/bmah_regs.sv
hw/rtl/bmah_div.sv
hw/rtl/battery_monitor_avg_hysteresis.sv
dv/bmah_checker.sv
dv/battery_monitor_avg_hysteresis_test.sv
